/* rtl/core/sq8_pkg.sv */
`default_nettype none

package sq8_pkg;

    // Default sample width of the top level.
    localparam int SAMPLE_BITS_DEFAULT = 16;

    // Largest quantized magnitude and the number of quotient bits it needs.
    localparam int QMAX = 127;
    localparam int QUOT_BITS = 7;
    localparam int QUANT_BITS = 8;
    localparam int STEP_BITS = 3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic scan;
        logic capture;
        logic mul;
        logic div_step;
        logic publish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_last;
    } status_t;

endpackage

`default_nettype wire

/* rtl/core/sq8_ctrl.sv */
`default_nettype none

module sq8_ctrl (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               item_valid,
    output logic              item_stall,
    input  wire               kind,
    output logic              result_valid,
    input  wire               result_stall,
    input  sq8_pkg::status_t  status,
    output sq8_pkg::cmd_t     cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_PUB  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       result_valid_reg;
    logic       result_valid_next;
    logic       accept;

    // New requests are taken only while no quantize item is in flight.
    assign item_stall   = (state_reg != ST_IDLE);
    assign accept       = item_valid && !item_stall;
    assign result_valid = result_valid_reg;

    // Next state, commands and output slot handling.
    always_comb
    begin
        state_next        = state_reg;
        cmd               = '0;
        result_valid_next = result_valid_reg && result_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (kind)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = ST_MUL;
                    end
                    else
                    begin
                        cmd.scan = 1'b1;
                    end
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_PUB;
                end
            end
            ST_PUB:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    cmd.publish       = 1'b1;
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and output valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // A published result is offered in the next cycle.
    a_publish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |=> result_valid_reg)
        else $error("published result not offered");

    // The divider hands over to the output stage after its last step.
    a_div_to_pub: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && status.div_last) |=> state_reg == ST_PUB)
        else $error("divider did not finish into the output stage");

    // A captured quantize request always enters the multiply stage.
    a_capture_mul: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == ST_MUL)
        else $error("captured request skipped the multiply stage");

    // No request is taken in while a quantize item is in flight.
    a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !(cmd.scan || cmd.capture))
        else $error("request taken while busy");

endmodule

`default_nettype wire

/* rtl/core/sq8_datapath.sv */
`default_nettype none

module sq8_datapath #(
    parameter int SAMPLE_BITS = sq8_pkg::SAMPLE_BITS_DEFAULT
) (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  sq8_pkg::cmd_t                          cmd,
    output sq8_pkg::status_t                       status,
    input  wire signed [SAMPLE_BITS-1:0]           sample,
    input  wire                                    first,
    output logic signed [sq8_pkg::QUANT_BITS-1:0]  quantized
);

    localparam int PROD_BITS = SAMPLE_BITS + sq8_pkg::QUOT_BITS;

    logic [SAMPLE_BITS-1:0]            sample_mag;
    logic [SAMPLE_BITS-1:0]            scan_base;
    logic [SAMPLE_BITS-1:0]            max_reg;
    logic [SAMPLE_BITS-1:0]            mag_reg;
    logic                              neg_reg;
    logic [PROD_BITS-1:0]              prod;
    logic [SAMPLE_BITS-1:0]            rem_reg;
    logic [sq8_pkg::QUOT_BITS-1:0]     low_reg;
    logic [sq8_pkg::QUOT_BITS-1:0]     quot_reg;
    logic [sq8_pkg::STEP_BITS-1:0]     step_reg;
    logic                              zero_reg;
    logic                              sat_reg;
    logic [SAMPLE_BITS:0]              rem_shift;
    logic [SAMPLE_BITS:0]              rem_diff;
    logic                              rem_ge;
    logic [sq8_pkg::QUOT_BITS-1:0]     quot_final;
    logic [sq8_pkg::QUANT_BITS-1:0]    quot_ext;
    logic [sq8_pkg::QUANT_BITS-1:0]    result_reg;

    // Magnitude of the incoming sample; the most negative value maps exactly.
    assign sample_mag = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
    assign scan_base  = first ? '0 : max_reg;

    // Magnitude times 127 as a shift and a subtract.
    assign prod = (PROD_BITS'(mag_reg) << sq8_pkg::QUOT_BITS) - PROD_BITS'(mag_reg);

    // One restoring division step.
    assign rem_shift = {rem_reg, low_reg[sq8_pkg::QUOT_BITS-1]};
    assign rem_diff  = rem_shift - {1'b0, max_reg};
    assign rem_ge    = (rem_shift >= {1'b0, max_reg});

    assign status.div_last = (step_reg == sq8_pkg::STEP_BITS'(sq8_pkg::QUOT_BITS - 1));

    // Empty tensor gives zero; a sample above the scanned maximum saturates.
    always_comb
    begin
        if (zero_reg)
        begin
            quot_final = '0;
        end
        else if (sat_reg)
        begin
            quot_final = sq8_pkg::QUOT_BITS'(sq8_pkg::QMAX);
        end
        else
        begin
            quot_final = quot_reg;
        end
        quot_ext = {1'b0, quot_final};
    end

    assign quantized = result_reg;

    // Maximum magnitude and divider step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg  <= '0;
            step_reg <= '0;
        end
        else
        begin
            if (cmd.scan)
            begin
                max_reg <= (sample_mag > scan_base) ? sample_mag : scan_base;
            end
            if (cmd.mul)
            begin
                step_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    // Operand capture, divider and result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mag_reg <= sample_mag;
            neg_reg <= sample[SAMPLE_BITS-1];
        end
        if (cmd.mul)
        begin
            rem_reg  <= prod[PROD_BITS-1:sq8_pkg::QUOT_BITS];
            low_reg  <= prod[sq8_pkg::QUOT_BITS-1:0];
            quot_reg <= '0;
            zero_reg <= (max_reg == '0);
            sat_reg  <= (mag_reg > max_reg);
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= rem_ge ? rem_diff[SAMPLE_BITS-1:0] : rem_shift[SAMPLE_BITS-1:0];
            low_reg  <= low_reg << 1;
            quot_reg <= {quot_reg[sq8_pkg::QUOT_BITS-2:0], rem_ge};
        end
        if (cmd.publish)
        begin
            result_reg <= neg_reg ? (~quot_ext + 1'b1) : quot_ext;
        end
    end

    // The partial remainder stays below the divisor on the normal path.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_step && !zero_reg && !sat_reg) |-> rem_reg < max_reg)
        else $error("partial remainder not below divisor");

    // An all-zero tensor quantizes to zero.
    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.publish && zero_reg) |=> result_reg == '0)
        else $error("all-zero tensor gave a nonzero result");

    // A scan leaves the maximum at least as large as the scanned magnitude.
    a_scan_max: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan |=> max_reg >= $past(sample_mag))
        else $error("maximum below scanned magnitude");

endmodule

`default_nettype wire

/* rtl/core/symmetric_int8_quantizer.sv */
`default_nettype none

// Symmetric per-tensor int8 quantizer. Stream the tensor twice: scan requests
// (kind 0, first set on the first one) update the stored maximum
// magnitude and produce nothing; quantize requests (kind 1) each produce
// trunc(sample * 127 / max) in -127..127, or 0 for an all-zero tensor, with a
// sample above the scanned maximum saturating to +/-127. For a quantize
// request the sample is captured at acceptance, then come a multiply-by-127
// step, seven steps of the restoring divider (one quotient bit per cycle) and
// an output step that offers the result; the next request is taken in the
// cycle after that, even while the result still waits in its output register.
// Backpressure on the result side adds cycles only when a second result is
// ready before the first has been taken.
module symmetric_int8_quantizer #(
    parameter int SAMPLE_BITS = sq8_pkg::SAMPLE_BITS_DEFAULT
) (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    item_valid,
    output logic                                   item_stall,
    input  wire                                    kind,
    input  wire signed [SAMPLE_BITS-1:0]           sample,
    input  wire                                    first,
    output logic                                   result_valid,
    input  wire                                    result_stall,
    output logic signed [sq8_pkg::QUANT_BITS-1:0]  quantized
);

    sq8_pkg::cmd_t    cmd;
    sq8_pkg::status_t status;

    // Sequencer for the request and result handshakes.
    sq8_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .kind         (kind),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    // Maximum tracking, multiply and divide.
    sq8_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .sample    (sample),
        .first     (first),
        .quantized (quantized)
    );

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`default_nettype none

module tb_top;

    localparam int SAMPLE_BITS = sq8_pkg::SAMPLE_BITS_DEFAULT;
    localparam int MAX_TENSOR = 16;
    localparam int RANDOM_REQUESTS = 340;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 24;

    // Request kinds on the kind input.
    localparam logic KIND_SCAN = 1'b0;
    localparam logic KIND_QUANT = 1'b1;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [sq8_pkg::QUANT_BITS-1:0] quant_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    logic kind = KIND_SCAN;
    sample_t sample = '0;
    logic first = 1'b0;
    logic result_valid;
    logic result_stall = 1'b0;
    quant_t quantized;

    // Own copy of the stored maximum magnitude, and the quantized values still owed.
    logic [SAMPLE_BITS-1:0] scanned_max = '0;
    quant_t pending_quant[$];

    int error_count = 0;
    int requests_sent = 0;
    int cycle_count = 0;
    int idle_pct = 34;
    int stall_pct = 34;

    symmetric_int8_quantizer #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .kind(kind),
        .sample(sample),
        .first(first),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .quantized(quantized)
    );

    always #10 clk = ~clk;

    // Magnitude of a sample; the most negative value is held exactly.
    function automatic int magnitude_of(sample_t s);
        int v;
        v = s;
        return (v < 0) ? -v : v;
    endfunction

    // Expected quantized value for a sample against the current scanned maximum.
    function automatic quant_t quantize_sample(sample_t s);
        int mag;
        int q;
        mag = magnitude_of(s);
        if (scanned_max == 0)
        begin
            q = 0;
        end
        else
        begin
            q = (mag * sq8_pkg::QMAX) / int'(scanned_max);
            if (q > sq8_pkg::QMAX)
            begin
                q = sq8_pkg::QMAX;
            end
        end
        if (s < 0)
        begin
            q = -q;
        end
        return quant_t'(q);
    endfunction

    // Random sample of a random magnitude range, so small and full-scale tensors both occur.
    function automatic sample_t random_sample(int bits);
        int v;
        v = int'($urandom_range(0, (1 << bits) - 1)) - (1 << (bits - 1));
        return sample_t'(v);
    endfunction

    // Send one request and update the prediction once it has been accepted.
    task automatic send_request(logic k, sample_t s, logic f);
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        kind <= k;
        sample <= s;
        first <= f;
        do
        begin
            @(posedge clk);
        end while (item_stall);
        requests_sent++;
        if (k == KIND_SCAN)
        begin
            if (f)
            begin
                scanned_max = '0;
            end
            if (magnitude_of(s) > int'(scanned_max))
            begin
                scanned_max = SAMPLE_BITS'(magnitude_of(s));
            end
        end
        else
        begin
            pending_quant.insert(pending_quant.size(), quantize_sample(s));
        end
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        while (pending_quant.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // A quantize request before any scan sees a zero maximum; an all-zero tensor gives zero.
    task automatic test_zero_maximum();
        send_request(KIND_QUANT, 16'sd100, 1'b0);
        send_request(KIND_SCAN, 16'sd0, 1'b1);
        send_request(KIND_SCAN, 16'sd0, 1'b0);
        send_request(KIND_QUANT, 16'sd0, 1'b0);
        send_request(KIND_QUANT, -16'sd5, 1'b0);
    endtask

    // Full-scale samples, including the most negative one as the maximum.
    task automatic test_extremes();
        send_request(KIND_SCAN, sample_t'(-32768), 1'b1);
        send_request(KIND_SCAN, sample_t'(32767), 1'b0);
        send_request(KIND_QUANT, sample_t'(-32768), 1'b0);
        send_request(KIND_QUANT, sample_t'(32767), 1'b0);
        send_request(KIND_QUANT, 16'sd1, 1'b0);
        send_request(KIND_QUANT, -16'sd1, 1'b0);
    endtask

    // Quantize samples above the scanned maximum, and one just below it.
    task automatic test_saturation();
        send_request(KIND_SCAN, 16'sd100, 1'b1);
        send_request(KIND_SCAN, -16'sd50, 1'b0);
        send_request(KIND_QUANT, 16'sd200, 1'b0);
        send_request(KIND_QUANT, -16'sd1000, 1'b0);
        send_request(KIND_QUANT, -16'sd99, 1'b0);
        send_request(KIND_QUANT, sample_t'(-32768), 1'b0);
    endtask

    // The first flag on a quantize request must leave the maximum alone.
    task automatic test_first_in_quantize();
        send_request(KIND_QUANT, 16'sd50, 1'b1);
        send_request(KIND_QUANT, 16'sd100, 1'b1);
        send_request(KIND_QUANT, -16'sd100, 1'b0);
    endtask

    // One random tensor: scan pass, then quantize pass, with occasional broken sequences.
    task automatic run_tensor();
        sample_t tensor[MAX_TENSOR];
        int len;
        int bits;
        int extra;
        len = $urandom_range(1, MAX_TENSOR);
        bits = $urandom_range(1, SAMPLE_BITS);
        for (int i = 0; i < len; i++)
        begin
            tensor[i] = random_sample(bits);
        end
        if ($urandom_range(7) == 0)
        begin
            tensor[$urandom_range(len - 1)] = $urandom_range(1) ? sample_t'(-32768)
                                                                 : sample_t'(32767);
        end
        for (int i = 0; i < len; i++)
        begin
            // Now and then the first flag is dropped, so the maximum carries over.
            send_request(KIND_SCAN, tensor[i], (i == 0) && ($urandom_range(7) != 0));
        end
        for (int i = 0; i < len; i++)
        begin
            send_request(KIND_QUANT, tensor[i], $urandom_range(3) == 0);
        end
        // Noise: requests of random kind, flag and sample.
        if ($urandom_range(5) == 0)
        begin
            extra = $urandom_range(1, 4);
            for (int i = 0; i < extra; i++)
            begin
                send_request(1'($urandom_range(1)),
                             random_sample(int'($urandom_range(1, SAMPLE_BITS))),
                             1'($urandom_range(1)));
            end
        end
    endtask

    // The sender holds off until every quantized value has come back.
    task automatic test_drain_pause();
        run_tensor();
        wait_drained();
        run_tensor();
    endtask

    // Random tensors, with one stretch where neither side idles.
    task automatic test_random_tensors();
        int tensor_count;
        int start_count;
        tensor_count = 0;
        start_count = requests_sent;
        while (requests_sent - start_count < RANDOM_REQUESTS)
        begin
            if (tensor_count >= 8 && tensor_count < 14)
            begin
                idle_pct = 0;
                stall_pct = 0;
            end
            else
            begin
                idle_pct = 34;
                stall_pct = 34;
            end
            run_tensor();
            tensor_count++;
        end
        idle_pct = 34;
        stall_pct = 34;
    endtask

    // Result side: random stall, and each accepted result checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_quant.size() == 0)
            begin
                $display("%0t: unexpected result quantized=%0d", $time, quantized);
                error_count++;
            end
            else
            begin
                if (quantized !== pending_quant[0])
                begin
                    $display("%0t: quantized mismatch expected=%0d actual=%0d",
                             $time, pending_quant[0], quantized);
                    error_count++;
                end
                void'(pending_quant.pop_front());
            end
        end
        result_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_zero_maximum();
        test_extremes();
        test_saturation();
        test_first_in_quantize();
        test_drain_pause();
        test_random_tensors();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_quant.size() == 0)
        begin
            $display("tb_top: done, clean");
        end
        else
        begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
rtl/core/sq8_pkg.sv
rtl/core/sq8_ctrl.sv
rtl/core/sq8_datapath.sv
rtl/core/symmetric_int8_quantizer.sv
verif/tb_top.sv
